// ===== hdl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, constants and pointer helpers for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH = 8;                    // entries in the circular store
   localparam int IDX_W = $clog2(DEPTH);        // store index width
   localparam int CNT_W = $clog2(DEPTH + 1);    // entry count width, holds DEPTH
   localparam int DATA_W = 32;
   localparam int OCC_W = 4;                    // occupancy field width

   // request codes
   localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
   localparam logic [1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [1:0] OP_POP_REAR   = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // store access for one cycle
   typedef struct packed {
      logic              wr_en;
      idx_type           wr_addr;
      logic [DATA_W-1:0] wr_data;
      idx_type           rd_addr;
   } ram_req_type;

   function automatic idx_type wrap_up(input idx_type i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_type'(i + 1'b1);
   endfunction

   function automatic idx_type wrap_down(input idx_type i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : idx_type'(i - 1'b1);
   endfunction

endpackage

// ===== hdl/cdq_store.sv =====
// ----------------------------------------------------------------------------
// cdq_store
// Deque storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cdq_store
   import cdq_pkg::*;
(
   input  logic              clock,
   input  ram_req_type       ram_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a circular store of DEPTH words.
// Latency: a request accepted at edge N has its result on the rsp_ ports in
//    the following cycle, strobed for exactly one cycle.
// Requests: no new request is taken while busy is high, which it is while the
//    result beat is presented; the store's registered read data sets this.
// Reset (synchronous, active high) empties the deque and zeroes both pointers;
//    store contents are left as they are. The receiver cannot stall.
// ----------------------------------------------------------------------------
module circular_deque
   import cdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic signed [DATA_W-1:0] req_push_value,
   // result channel
   output logic              rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_pop_value,
   output logic [1:0]        rsp_status,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   // one-hot sequencer: take a beat, then present its result
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RESP = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   idx_type     head_ff, head_in;
   idx_type     tail_ff, tail_in;
   cnt_type     count_ff, count_in;
   logic [1:0]  status_ff, status_in;
   logic        popped_ff, popped_in;   // result value comes from the store

   ram_req_type       ram_req;
   logic [DATA_W-1:0] rd_data;

   logic accept;
   logic is_full;
   logic is_empty;
   cnt_type count_dec;

   assign accept   = start && (state_ff == ST_IDLE);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign count_dec = count_ff - 1'b1;

   // Pointer, count and store access for the accepted beat. Pushes write
   // in the accept cycle; pops read here and the word shows up next cycle.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = status_ff;
      popped_in = popped_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = head_ff;
      ram_req.wr_data = req_push_value;
      ram_req.rd_addr = (req_type == OP_POP_FRONT) ? head_ff : tail_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_RESP;
               status_in = STAT_OK;
               popped_in = 1'b0;
               unique case (req_type)
                  OP_PUSH_FRONT, OP_PUSH_REAR: begin
                     priority if (is_full) begin
                        status_in = STAT_OVERFLOW;
                     end else if (is_empty) begin
                        // first entry always lands at index zero
                        head_in         = '0;
                        tail_in         = '0;
                        count_in        = CNT_W'(1);
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = '0;
                     end else if (req_type == OP_PUSH_FRONT) begin
                        head_in         = wrap_down(head_ff);
                        count_in        = count_ff + 1'b1;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = wrap_down(head_ff);
                     end else begin
                        tail_in         = wrap_up(tail_ff);
                        count_in        = count_ff + 1'b1;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = wrap_up(tail_ff);
                     end
                  end
                  OP_POP_FRONT, OP_POP_REAR: begin
                     if (is_empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        popped_in = 1'b1;
                        count_in  = count_dec;
                        // last element out: pointers stay put
                        if (count_dec != '0) begin
                           if (req_type == OP_POP_FRONT) begin
                              head_in = wrap_up(head_ff);
                           end else begin
                              tail_in = wrap_down(tail_ff);
                           end
                        end
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   cdq_store u_store (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // result beat: count_ff already holds the post-request occupancy
   assign busy          = (state_ff == ST_RESP);
   assign rsp_strobe    = (state_ff == ST_RESP);
   assign rsp_pop_value = popped_ff ? $signed(rd_data) : '0;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = OCC_W'(count_ff);

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted beat without result");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobed twice");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != STAT_OK) |-> rsp_pop_value == '0)
      else $error("failed request returned data");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == STAT_OVERFLOW) |-> count_ff == CNT_W'(DEPTH))
      else $error("overflow reported while not full");
`endif

endmodule
